FILE: rtl/core/planar_pose_integrator_assert.svh
// ---------------------------------------------------------------------------
// Planar pose integrator assertion macros
// Concurrent assertion shorthands; the caller supplies clk and arst_n.
// ---------------------------------------------------------------------------
`ifndef PLANAR_POSE_INTEGRATOR_ASSERT_SVH
`define PLANAR_POSE_INTEGRATOR_ASSERT_SVH

// same-cycle implication
`define PPI_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppi assertion failed");

// next-cycle implication
`define PPI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppi assertion failed");

`endif

FILE: rtl/core/ppi_pkg.sv
// ---------------------------------------------------------------------------
// Planar pose integrator package
// Widths, CORDIC angle table and controller/datapath command types.
// ---------------------------------------------------------------------------
package ppi_pkg;

	localparam int VEL_W   = 24;
	localparam int YAW_W   = 32;
	localparam int DT_W    = 16;
	localparam int POS_W   = 40;
	localparam int HDG_W   = 24;
	localparam int CW      = 36;                 // CORDIC x/y width, Q.24
	localparam int ZW      = 24;                 // residual angle width
	localparam int MB_W    = 25;                 // second multiplier operand
	localparam int PROD_W  = CW + MB_W;

	localparam int ROTATION_STEPS  = 20;
	localparam int ANGLE_TABLE_LEN = 24;
	localparam int CORDIC_ITERS    = (ROTATION_STEPS < ANGLE_TABLE_LEN) ?
		ROTATION_STEPS : ANGLE_TABLE_LEN;
	localparam int ITER_W          = $clog2(ANGLE_TABLE_LEN);

	localparam logic signed [MB_W-1:0] INV_GAIN_Q24 = 25'sd10188014;

	typedef enum logic [2:0] {
		MOP_GAIN_X,
		MOP_GAIN_Y,
		MOP_SCALE_X,
		MOP_SCALE_Y,
		MOP_SCALE_H
	} mop_t;

	typedef struct packed {
		logic accept;
		logic init;
		logic rotate;
		logic quad;
		logic mul_en;
		mop_t mop;
		logic commit;
	} ppi_cmd_t;

	typedef struct packed {
		logic last_iter;
	} ppi_stat_t;

	// arctan(2^-i) in 2^-24 turn units
	function automatic logic signed [ZW-1:0] atan_turn(input logic [ITER_W-1:0] i);
		logic signed [ZW-1:0] a;
		case (i)
			5'd0:    a = 24'sd2097152;
			5'd1:    a = 24'sd1238021;
			5'd2:    a = 24'sd654136;
			5'd3:    a = 24'sd332050;
			5'd4:    a = 24'sd166669;
			5'd5:    a = 24'sd83416;
			5'd6:    a = 24'sd41718;
			5'd7:    a = 24'sd20860;
			5'd8:    a = 24'sd10430;
			5'd9:    a = 24'sd5215;
			5'd10:   a = 24'sd2608;
			5'd11:   a = 24'sd1304;
			5'd12:   a = 24'sd652;
			5'd13:   a = 24'sd326;
			5'd14:   a = 24'sd163;
			5'd15:   a = 24'sd81;
			5'd16:   a = 24'sd41;
			5'd17:   a = 24'sd20;
			5'd18:   a = 24'sd10;
			5'd19:   a = 24'sd5;
			5'd20:   a = 24'sd3;
			5'd21:   a = 24'sd1;
			5'd22:   a = 24'sd1;
			default: a = 24'sd0;
		endcase
		return a;
	endfunction

endpackage

FILE: rtl/core/ppi_if.sv
// ---------------------------------------------------------------------------
// Planar pose integrator channels
// Valid/ready channels for the step input and the pose result.
// ---------------------------------------------------------------------------
interface ppi_in_if import ppi_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [VEL_W-1:0] body_velocity_fwd;
	logic signed [VEL_W-1:0] body_velocity_side;
	logic signed [YAW_W-1:0] yaw_rate;
	logic signed [VEL_W-1:0] drift_velocity_x;
	logic signed [VEL_W-1:0] drift_velocity_y;
	logic [DT_W-1:0]         step_time;
	logic                    load_pose;
	logic signed [POS_W-1:0] new_pos_x;
	logic signed [POS_W-1:0] new_pos_y;
	logic [HDG_W-1:0]        new_heading;

	modport source (
		output valid, body_velocity_fwd, body_velocity_side, yaw_rate,
			drift_velocity_x, drift_velocity_y, step_time, load_pose,
			new_pos_x, new_pos_y, new_heading,
		input  ready
	);
	modport sink (
		input  valid, body_velocity_fwd, body_velocity_side, yaw_rate,
			drift_velocity_x, drift_velocity_y, step_time, load_pose,
			new_pos_x, new_pos_y, new_heading,
		output ready
	);
endinterface

interface ppi_out_if import ppi_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic [HDG_W-1:0]        heading;

	modport source (output valid, pos_x, pos_y, heading, input ready);
	modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

FILE: rtl/core/ppi_ctrl.sv
// ---------------------------------------------------------------------------
// Planar pose integrator controller
// Sequences load, CORDIC iterations, quadrant fix, multiplies and commit.
// ---------------------------------------------------------------------------
module ppi_ctrl import ppi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  ppi_stat_t stat,
	output ppi_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_ROT,
		S_QUAD,
		S_GX,
		S_GY,
		S_SX,
		S_SY,
		S_SH,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd        = '0;
		cmd.mop    = MOP_GAIN_X;
		cmd.accept = in_valid && (state_q == S_IDLE);
		cmd.init   = (state_q == S_INIT);
		cmd.rotate = (state_q == S_ROT);
		cmd.quad   = (state_q == S_QUAD);
		cmd.commit = (state_q == S_COMMIT) && out_free;
		case (state_q)
			S_GX: begin
				cmd.mul_en = 1'b1;
				cmd.mop    = MOP_GAIN_X;
			end
			S_GY: begin
				cmd.mul_en = 1'b1;
				cmd.mop    = MOP_GAIN_Y;
			end
			S_SX: begin
				cmd.mul_en = 1'b1;
				cmd.mop    = MOP_SCALE_X;
			end
			S_SY: begin
				cmd.mul_en = 1'b1;
				cmd.mop    = MOP_SCALE_Y;
			end
			S_SH: begin
				cmd.mul_en = 1'b1;
				cmd.mop    = MOP_SCALE_H;
			end
			default: begin
				cmd.mul_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_INIT;
				S_INIT:   state_q <= S_ROT;
				S_ROT:    if (stat.last_iter) state_q <= S_QUAD;
				S_QUAD:   state_q <= S_GX;
				S_GX:     state_q <= S_GY;
				S_GY:     state_q <= S_SX;
				S_SX:     state_q <= S_SY;
				S_SY:     state_q <= S_SH;
				S_SH:     state_q <= S_COMMIT;
				S_COMMIT: if (out_free) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/core/ppi_datapath.sv
// ---------------------------------------------------------------------------
// Planar pose integrator datapath
// Stored pose, serial CORDIC, shared multiplier and saturating update.
// ---------------------------------------------------------------------------
module ppi_datapath import ppi_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ppi_cmd_t                cmd,
	output ppi_stat_t               stat,
	input  logic signed [VEL_W-1:0] body_velocity_fwd,
	input  logic signed [VEL_W-1:0] body_velocity_side,
	input  logic signed [YAW_W-1:0] yaw_rate,
	input  logic signed [VEL_W-1:0] drift_velocity_x,
	input  logic signed [VEL_W-1:0] drift_velocity_y,
	input  logic [DT_W-1:0]         step_time,
	input  logic                    load_pose,
	input  logic signed [POS_W-1:0] new_pos_x,
	input  logic signed [POS_W-1:0] new_pos_y,
	input  logic [HDG_W-1:0]        new_heading,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic [HDG_W-1:0]        heading
);

	localparam logic [1:0] QUAD_90  = 2'd1;
	localparam logic [1:0] QUAD_180 = 2'd2;
	localparam logic [1:0] QUAD_270 = 2'd3;

	localparam logic signed [POS_W:0] POS_MAX = {2'b00, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W:0] POS_MIN = {2'b11, {(POS_W-1){1'b0}}};

	// step operands
	logic signed [VEL_W-1:0] fwd_q, side_q, drx_q, dry_q;
	logic signed [YAW_W-1:0] yaw_q;
	logic [DT_W-1:0]         dt_q;

	// pose state
	logic signed [POS_W-1:0] stored_x_q, stored_y_q;
	logic [HDG_W-1:0]        stored_h_q;

	// CORDIC
	logic signed [CW-1:0]    x_q, y_q;
	logic signed [ZW-1:0]    z_q;
	logic [1:0]              quad_q;
	logic [ITER_W-1:0]       iter_q;
	logic signed [CW-1:0]    x_sh, y_sh;
	logic signed [ZW-1:0]    ang;

	// multiplier and results
	logic signed [CW-1:0]     rx_q, ry_q, dpx_q, dpy_q;
	logic [HDG_W-1:0]         dh_q;
	logic signed [CW-1:0]     drx_ext, dry_ext;
	logic signed [CW-1:0]     mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] prod, rnd, prod_rnd, sh24, sh16;

	// output register
	logic signed [POS_W-1:0] out_x_q, out_y_q;
	logic [HDG_W-1:0]        out_h_q;

	// commit
	logic signed [POS_W:0]   sum_x, sum_y;
	logic signed [POS_W-1:0] sat_x, sat_y;
	logic [HDG_W-1:0]        next_h;

	assign stat.last_iter = (iter_q == ITER_W'(CORDIC_ITERS - 1));

	assign x_sh = x_q >>> iter_q;
	assign y_sh = y_q >>> iter_q;
	assign ang  = atan_turn(iter_q);

	assign drx_ext = $signed({{(CW-VEL_W-8){drx_q[VEL_W-1]}}, drx_q, 8'b0});
	assign dry_ext = $signed({{(CW-VEL_W-8){dry_q[VEL_W-1]}}, dry_q, 8'b0});

	always_comb begin
		case (cmd.mop)
			MOP_GAIN_X: begin
				mul_a = x_q;
				mul_b = INV_GAIN_Q24;
				rnd   = '0;
			end
			MOP_GAIN_Y: begin
				mul_a = y_q;
				mul_b = INV_GAIN_Q24;
				rnd   = '0;
			end
			MOP_SCALE_X: begin
				mul_a = rx_q + drx_ext;
				mul_b = $signed({{(MB_W-DT_W){1'b0}}, dt_q});
				rnd   = PROD_W'(1) <<< 23;
			end
			MOP_SCALE_Y: begin
				mul_a = ry_q + dry_ext;
				mul_b = $signed({{(MB_W-DT_W){1'b0}}, dt_q});
				rnd   = PROD_W'(1) <<< 23;
			end
			MOP_SCALE_H: begin
				mul_a = CW'(yaw_q);
				mul_b = $signed({{(MB_W-DT_W){1'b0}}, dt_q});
				rnd   = PROD_W'(1) <<< 15;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
				rnd   = '0;
			end
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign prod_rnd = prod + rnd;
	assign sh24     = prod_rnd >>> 24;
	assign sh16     = prod_rnd >>> 16;

	assign sum_x  = {stored_x_q[POS_W-1], stored_x_q} + (POS_W+1)'(dpx_q);
	assign sum_y  = {stored_y_q[POS_W-1], stored_y_q} + (POS_W+1)'(dpy_q);
	assign sat_x  = (sum_x[POS_W] != sum_x[POS_W-1]) ?
		POS_W'(sum_x[POS_W] ? POS_MIN : POS_MAX) : sum_x[POS_W-1:0];
	assign sat_y  = (sum_y[POS_W] != sum_y[POS_W-1]) ?
		POS_W'(sum_y[POS_W] ? POS_MIN : POS_MAX) : sum_y[POS_W-1:0];
	assign next_h = stored_h_q + dh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_x_q <= '0;
			stored_y_q <= '0;
			stored_h_q <= '0;
		end else if (cmd.accept && load_pose) begin
			stored_x_q <= new_pos_x;
			stored_y_q <= new_pos_y;
			stored_h_q <= new_heading;
		end else if (cmd.commit) begin
			stored_x_q <= sat_x;
			stored_y_q <= sat_y;
			stored_h_q <= next_h;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (cmd.init) begin
			iter_q <= '0;
		end else if (cmd.rotate) begin
			iter_q <= iter_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			fwd_q  <= body_velocity_fwd;
			side_q <= body_velocity_side;
			yaw_q  <= yaw_rate;
			drx_q  <= drift_velocity_x;
			dry_q  <= drift_velocity_y;
			dt_q   <= step_time;
		end

		if (cmd.init) begin
			x_q    <= $signed({{(CW-VEL_W-8){fwd_q[VEL_W-1]}}, fwd_q, 8'b0});
			y_q    <= $signed({{(CW-VEL_W-8){side_q[VEL_W-1]}}, side_q, 8'b0});
			z_q    <= $signed({2'b00, stored_h_q[HDG_W-3:0]});
			quad_q <= stored_h_q[HDG_W-1:HDG_W-2];
		end else if (cmd.rotate) begin
			if (!z_q[ZW-1]) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + ang;
			end
		end else if (cmd.quad) begin
			case (quad_q)
				QUAD_90: begin
					x_q <= -y_q;
					y_q <= x_q;
				end
				QUAD_180: begin
					x_q <= -x_q;
					y_q <= -y_q;
				end
				QUAD_270: begin
					x_q <= y_q;
					y_q <= -x_q;
				end
				default: begin
					x_q <= x_q;
					y_q <= y_q;
				end
			endcase
		end

		if (cmd.mul_en) begin
			case (cmd.mop)
				MOP_GAIN_X:  rx_q  <= sh24[CW-1:0];
				MOP_GAIN_Y:  ry_q  <= sh24[CW-1:0];
				MOP_SCALE_X: dpx_q <= sh24[CW-1:0];
				MOP_SCALE_Y: dpy_q <= sh24[CW-1:0];
				MOP_SCALE_H: dh_q  <= sh16[HDG_W-1:0];
				default:     dh_q  <= dh_q;
			endcase
		end

		if (cmd.commit) begin
			out_x_q <= sat_x;
			out_y_q <= sat_y;
			out_h_q <= next_h;
		end
	end

	assign pos_x   = out_x_q;
	assign pos_y   = out_y_q;
	assign heading = out_h_q;

endmodule

FILE: rtl/core/planar_pose_integrator.sv
// A result becomes valid after its step transaction passes through load,
// CORDIC_ITERS rotations, quadrant fix, five multiplies and commit.
// One step transaction is in flight at a time, set by the serial CORDIC loop
// and the single shared multiplier; a held result stalls only the next commit.
// Reset (arst_n low, asynchronous): pose clears to zero, controller idles, no result pending.
// ---------------------------------------------------------------------------
// Planar pose integrator
// Dead-reckoning pose update from body velocity, drift, yaw rate and step time.
// ---------------------------------------------------------------------------
module planar_pose_integrator import ppi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	ppi_in_if.sink   step_in,
	ppi_out_if.source pose_out
);

	ppi_cmd_t  cmd;
	ppi_stat_t stat;

	ppi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (step_in.valid),
		.in_ready  (step_in.ready),
		.out_valid (pose_out.valid),
		.out_ready (pose_out.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ppi_datapath u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.body_velocity_fwd  (step_in.body_velocity_fwd),
		.body_velocity_side (step_in.body_velocity_side),
		.yaw_rate           (step_in.yaw_rate),
		.drift_velocity_x   (step_in.drift_velocity_x),
		.drift_velocity_y   (step_in.drift_velocity_y),
		.step_time          (step_in.step_time),
		.load_pose          (step_in.load_pose),
		.new_pos_x          (step_in.new_pos_x),
		.new_pos_y          (step_in.new_pos_y),
		.new_heading        (step_in.new_heading),
		.pos_x              (pose_out.pos_x),
		.pos_y              (pose_out.pos_y),
		.heading            (pose_out.heading)
	);

endmodule

FILE: rtl/core/ppi_checker.sv
// ---------------------------------------------------------------------------
// Planar pose integrator port checker
// Port-level checks on result holding and step sequencing.
// ---------------------------------------------------------------------------
`include "planar_pose_integrator_assert.svh"

module ppi_checker import ppi_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [POS_W-1:0] pos_x,
	input logic signed [POS_W-1:0] pos_y,
	input logic [HDG_W-1:0]        heading
);

	logic in_take;
	logic out_stall;

	assign in_take   = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;

	`PPI_ASSERT_NEXT(a_out_held, out_stall, out_valid)
	`PPI_ASSERT_NEXT(a_out_stable, out_stall, $stable(pos_x) && $stable(pos_y) && $stable(heading))
	`PPI_ASSERT_NEXT(a_one_step_at_a_time, in_take, !in_ready)
	`PPI_ASSERT_NEXT(a_no_instant_result, in_take, !$rose(out_valid))
	`PPI_ASSERT_SAME(a_ready_known, in_take, !$isunknown(in_ready))

endmodule

bind planar_pose_integrator ppi_checker u_ppi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (step_in.valid),
	.in_ready  (step_in.ready),
	.out_valid (pose_out.valid),
	.out_ready (pose_out.ready),
	.pos_x     (pose_out.pos_x),
	.pos_y     (pose_out.pos_y),
	.heading   (pose_out.heading)
);
